[sv/mma_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mma_pkg;

  localparam int MAX_DIM = 16;
  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int DIM_W = 5;
  localparam int OPD_W = 16;
  localparam int ACC_W = 48;
  localparam int PROD_W = 2 * OPD_W;
  // old value plus MAX_DIM full-scale products, with one spare bit
  localparam int SUM_W = ACC_W + $clog2(MAX_DIM) + 2;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    ACT_WR_A = 3'd0,
    ACT_WR_B = 3'd1,
    ACT_WR_C = 3'd2,
    ACT_MUL  = 3'd3,
    ACT_RD_C = 3'd4
  } action_e;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_SAT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd2;

  typedef struct packed {
    logic [2:0]              action;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [OPD_W-1:0] operand_value;
    logic signed [ACC_W-1:0] accum_value;
  } in_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] read_value;
    logic [1:0]              status;
  } out_item_t;

  // element write broadcast to the cells
  typedef struct packed {
    logic                    we_a;
    logic                    we_b;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [OPD_W-1:0] value;
  } wr_bus_t;

  // one C element travelling down the chain
  typedef struct packed {
    logic                    valid;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [SUM_W-1:0] sum;
  } token_t;

  function automatic logic [DIM_W-1:0] eff_size(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] lim;
    lim = DIM_W'(MAX_DIM);
    return (v > lim) ? lim : v;
  endfunction

endpackage

`default_nettype wire

[sv/mma_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module mma_cell (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [mma_pkg::IDX_W-1:0] idx_i,
  input  wire logic [mma_pkg::DIM_W-1:0] inner_i,
  input  wire mma_pkg::wr_bus_t         wr_i,
  input  wire mma_pkg::token_t          tok_i,
  output mma_pkg::token_t               tok_o
);
  import mma_pkg::*;

  // column idx of A and row idx of B
  logic signed [OPD_W-1:0] a_col_q [MAX_DIM];
  logic signed [OPD_W-1:0] b_row_q [MAX_DIM];
  logic signed [PROD_W-1:0] prod;
  logic active;
  logic tok_valid_q;
  logic [IDX_W-1:0] tok_row_q, tok_col_q;
  logic signed [SUM_W-1:0] sum_d, sum_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we_a && wr_i.col == idx_i) begin
      a_col_q[wr_i.row] <= wr_i.value;
    end
    if (wr_i.we_b && wr_i.row == idx_i) begin
      b_row_q[wr_i.col] <= wr_i.value;
    end
  end

  assign active = ({1'b0, idx_i} < inner_i);
  assign prod = a_col_q[tok_i.row] * b_row_q[tok_i.col];
  assign sum_d = active ? (tok_i.sum + SUM_W'(prod)) : tok_i.sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_row_q <= tok_i.row;
    tok_col_q <= tok_i.col;
    sum_q     <= sum_d;
  end

  assign tok_o = '{valid: tok_valid_q, row: tok_row_q, col: tok_col_q, sum: sum_q};

endmodule

`default_nettype wire

[sv/matrix_multiply_accumulate.sv]
`timescale 1ns / 1ps
`default_nettype none

// Matrix multiply-accumulate engine, C += A*B on Q1.15 operands with a saturating
// Q18.30 accumulator. Each input beat writes one element of A, B or C, starts the
// multiply, or reads one C element, and yields exactly one result beat. A, B and C
// keep their contents between items; C is zero after reset with no clearing pass,
// A and B hold nothing useful until written. Element writes and bad items pass
// through the done state to the output register; C reads first pass a read-wait
// state. In a multiply, C elements enter a chain of MAX_DIM multiply-accumulate
// cells one per cycle through the single read port of the C memory, cell k adding
// A[i][k]*B[k][j], and the last element needs the chain depth to drain. The block
// takes one item at a time; a result waiting at the output does not hold off the
// next input beat.
module matrix_multiply_accumulate (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire mma_pkg::in_item_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output mma_pkg::out_item_t                 out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [mma_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [mma_pkg::DIM_W-1:0]     cfg_data_i
);
  import mma_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDW   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam int DRAIN_LEN = MAX_DIM + 4;
  localparam int DRN_W = $clog2(DRAIN_LEN + 1);

  localparam logic signed [SUM_W-1:0] SUM_MAX =
    {{(SUM_W - ACC_W + 1){1'b0}}, {(ACC_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = ~SUM_MAX;

  logic [2:0] state_q, state_d;
  logic [DIM_W-1:0] rows_q, inner_q, cols_q;
  logic [DIM_W-1:0] n_eff, p_eff, m_eff;
  logic in_acc;
  logic out_free;

  logic [IDX_W-1:0] i_q, i_d, j_q, j_d;
  logic [DRN_W-1:0] drain_q, drain_d;
  logic sat_q, sat_d;
  logic [1:0] res_status_q, res_status_d;
  logic signed [ACC_W-1:0] res_value_q, res_value_d;

  logic out_valid_q;
  out_item_t out_q;

  logic ok_a, ok_b, ok_c;
  wr_bus_t wr_bus;

  logic signed [ACC_W-1:0] c_mem [DEPTH];
  logic [DEPTH-1:0] c_vld_q;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic c_we;
  logic signed [ACC_W-1:0] c_wdata;
  logic signed [ACC_W-1:0] c_rd_q;
  logic c_rd_vld_q;

  logic iss_vld_q;
  logic [IDX_W-1:0] iss_row_q, iss_col_q;
  token_t tok [MAX_DIM + 1];
  token_t exit_tok;
  logic exit_sat;
  logic signed [ACC_W-1:0] exit_val;

  assign n_eff = eff_size(rows_q);
  assign p_eff = eff_size(inner_q);
  assign m_eff = eff_size(cols_q);

  assign cfg_ready_o = 1'b1;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DIM_W'(MAX_DIM);
      inner_q <= DIM_W'(MAX_DIM);
      cols_q  <= DIM_W'(MAX_DIM);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ROWS:  rows_q  <= cfg_data_i;
        CFG_INNER: inner_q <= cfg_data_i;
        CFG_COLS:  cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ok_a = ({1'b0, in_data_i.row_index} < n_eff) && ({1'b0, in_data_i.col_index} < p_eff);
  assign ok_b = ({1'b0, in_data_i.row_index} < p_eff) && ({1'b0, in_data_i.col_index} < m_eff);
  assign ok_c = ({1'b0, in_data_i.row_index} < n_eff) && ({1'b0, in_data_i.col_index} < m_eff);

  always_comb begin
    wr_bus.we_a  = in_acc && (in_data_i.action == ACT_WR_A) && ok_a;
    wr_bus.we_b  = in_acc && (in_data_i.action == ACT_WR_B) && ok_b;
    wr_bus.row   = in_data_i.row_index;
    wr_bus.col   = in_data_i.col_index;
    wr_bus.value = in_data_i.operand_value;
  end

  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    j_d          = j_q;
    drain_d      = drain_q;
    sat_d        = sat_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_value_d = '0;
          state_d     = S_DONE;
          case (in_data_i.action)
            ACT_WR_A: res_status_d = ok_a ? STAT_OK : STAT_RANGE;
            ACT_WR_B: res_status_d = ok_b ? STAT_OK : STAT_RANGE;
            ACT_WR_C: res_status_d = ok_c ? STAT_OK : STAT_RANGE;
            ACT_RD_C: begin
              res_status_d = ok_c ? STAT_OK : STAT_RANGE;
              state_d      = S_RDW;
            end
            ACT_MUL: begin
              i_d   = '0;
              j_d   = '0;
              sat_d = 1'b0;
              if (n_eff == '0 || m_eff == '0) begin
                drain_d = DRN_W'(DRAIN_LEN);
                state_d = S_DRAIN;
              end else begin
                state_d = S_MUL;
              end
            end
            default: res_status_d = STAT_RANGE;
          endcase
        end
      end
      S_RDW: begin
        if (res_status_q == STAT_OK && c_rd_vld_q) begin
          res_value_d = c_rd_q;
        end
        state_d = S_DONE;
      end
      S_MUL: begin
        if ({1'b0, j_q} == m_eff - 1'b1) begin
          j_d = '0;
          if ({1'b0, i_q} == n_eff - 1'b1) begin
            drain_d = DRN_W'(DRAIN_LEN);
            state_d = S_DRAIN;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (drain_q == '0) begin
          res_value_d  = '0;
          res_status_d = (sat_q || (exit_tok.valid && exit_sat)) ? STAT_SAT : STAT_OK;
          state_d      = S_DONE;
        end else begin
          drain_d = drain_q - 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (exit_tok.valid && exit_sat) begin
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sat_q       <= 1'b0;
      drain_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sat_q   <= sat_d;
      drain_q <= drain_d;
      i_q     <= i_d;
      j_q     <= j_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    if (state_q == S_DONE && out_free) begin
      out_q.read_value <= res_value_q;
      out_q.status     <= res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  // c memory: one read and one write port, valid bits stand in for the zero reset
  assign rd_addr = (state_q == S_MUL) ? {i_q, j_q}
                                      : {in_data_i.row_index, in_data_i.col_index};

  always_comb begin
    if (exit_tok.valid) begin
      c_we    = 1'b1;
      wr_addr = {exit_tok.row, exit_tok.col};
      c_wdata = exit_val;
    end else begin
      c_we    = in_acc && (in_data_i.action == ACT_WR_C) && ok_c;
      wr_addr = {in_data_i.row_index, in_data_i.col_index};
      c_wdata = in_data_i.accum_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      c_mem[wr_addr] <= c_wdata;
    end
    c_rd_q <= c_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q    <= '0;
      c_rd_vld_q <= 1'b0;
      iss_vld_q  <= 1'b0;
    end else begin
      if (c_we) begin
        c_vld_q[wr_addr] <= 1'b1;
      end
      c_rd_vld_q <= c_vld_q[rd_addr];
      iss_vld_q  <= (state_q == S_MUL);
    end
  end

  always_ff @(posedge clk_i) begin
    iss_row_q <= i_q;
    iss_col_q <= j_q;
  end

  assign tok[0] = '{valid: iss_vld_q, row: iss_row_q, col: iss_col_q,
                    sum: c_rd_vld_q ? SUM_W'(c_rd_q) : '0};

  for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
    mma_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(k)),
      .inner_i (p_eff),
      .wr_i    (wr_bus),
      .tok_i   (tok[k]),
      .tok_o   (tok[k+1])
    );
  end

  assign exit_tok = tok[MAX_DIM];

  always_comb begin
    exit_sat = 1'b0;
    exit_val = exit_tok.sum[ACC_W-1:0];
    if (exit_tok.sum > SUM_MAX) begin
      exit_sat = 1'b1;
      exit_val = SUM_MAX[ACC_W-1:0];
    end else if (exit_tok.sum < SUM_MIN) begin
      exit_sat = 1'b1;
      exit_val = SUM_MIN[ACC_W-1:0];
    end
  end

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status != 2'd3))
    else $error("result status code out of range");

  a_value_ok_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.read_value != '0) |-> (out_data_o.status == STAT_OK))
    else $error("nonzero read value with error status");

  a_mul_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.action == ACT_MUL) |=> (state_q == S_MUL || state_q == S_DRAIN))
    else $error("multiply beat did not start the sweep");

  a_chain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !exit_tok.valid)
    else $error("chain still writing C while idle");

endmodule

`default_nettype wire
